### hw/rtl/cfr_pkg.sv
// Shared types and fixed field widths for the convolution reverb FIR block.
// Used by cfr_mac and convolution_reverb_fir; depends on nothing else.
`timescale 1ns / 1ps

package cfr_pkg;

    localparam int SAMPLE_W    = 16;  // Q1.15 samples and taps
    localparam int OUT_W       = 32;  // saturated result width
    localparam int FRAC_W      = 15;  // fraction bits dropped from the sum
    localparam int TAP_COUNT_W = 13;
    localparam int TAP_INDEX_W = 12;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 2;
    localparam int M_TUSER_W   = 1;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;     // start a new sum
        logic rd_valid;  // memory read data is valid this cycle
    } cfr_mac_ctl_t;

endpackage

### hw/rtl/cfr_mac.sv
// Multiply-accumulate unit with the final shift and saturation of the sum.
// Depends on cfr_pkg for widths and the control struct.
`timescale 1ns / 1ps

module cfr_mac #(
    parameter int ACC_W = 59
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  cfr_pkg::cfr_mac_ctl_t              ctl,
    input  logic signed [cfr_pkg::SAMPLE_W-1:0] tap_q,
    input  logic signed [cfr_pkg::SAMPLE_W-1:0] hist_q,
    output logic                               busy,
    output logic        [cfr_pkg::OUT_W-1:0]    result,
    output logic                               sat
);

    localparam int PROD_W = 2 * cfr_pkg::SAMPLE_W;
    localparam int SH_W   = ACC_W - cfr_pkg::FRAC_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [SH_W-1:0]   shifted;
    logic [SH_W-cfr_pkg::OUT_W:0] upper;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctl.rd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_valid) begin
            prod_reg <= tap_q * hist_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Dropping the fraction bits of a two's complement sum rounds toward minus infinity.
    assign shifted = acc_reg[ACC_W-1:cfr_pkg::FRAC_W];
    assign upper   = shifted[SH_W-1:cfr_pkg::OUT_W-1];
    assign sat     = !((&upper) || (~|upper));

    always_comb begin
        if (!sat) begin
            result = shifted[cfr_pkg::OUT_W-1:0];
        end else if (shifted[SH_W-1]) begin
            result = {1'b1, {(cfr_pkg::OUT_W-1){1'b0}}};
        end else begin
            result = {1'b0, {(cfr_pkg::OUT_W-1){1'b1}}};
        end
    end

    assign busy = ctl.rd_valid | prod_vld_reg;

endmodule

### hw/rtl/convolution_reverb_fir.sv
// Convolution reverb FIR: top level with the tap and history memories and the sequencer.
// Depends on cfr_pkg and instantiates cfr_mac.
`timescale 1ns / 1ps

// The block convolves a stream of Q1.15 audio samples with a stored impulse
// response and restarts the convolution at every chunk. An input transfer
// with func (s_tuser[0]) low writes one tap into the tap memory and produces
// no result. An input transfer with func high appends the
// sample to the history memory and produces exactly one result: the sum of
// tap[k] * x[n-k] over k below min(tap_count, samples in the chunk so far,
// MAX_TAPS), shifted right by 15 with rounding toward minus infinity and
// saturated to 32 bits, with m_tuser[0] set when clipping happened. Setting
// chunk_start (s_tuser[1]) with a sample makes that sample the first of a new
// chunk, so older samples count as zero. A sample occupies the block from its
// transfer to the first cycle that can take the next transfer: the transfer
// cycle, then one read per cycle for each tap in use, since the tap and history
// memories each have one read port and a single multiplier forms one product
// per cycle, then the memory read, product and accumulate stages. With no taps
// in use it goes straight from its transfer to the result load. The result
// sits in an output register, so the next transfer is taken while it waits for
// m_tready; a later sum that finishes while that register is still full waits
// until it is taken. Taps never written read as undefined values and must be
// written before use. The user must write the tap_count register through the
// cfg channel only while no sample is in flight; the block does not enforce
// this. It resets to 1 and values above MAX_TAPS act as MAX_TAPS.

module convolution_reverb_fir #(
    parameter int MAX_TAPS = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cfr_pkg::S_TDATA_W-1:0]     s_tdata,   // [11:0] tap_index, [27:12] value
    input  logic [cfr_pkg::S_TUSER_W-1:0]     s_tuser,   // [0] func, [1] chunk_start
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cfr_pkg::OUT_W-1:0]         m_tdata,   // [31:0] reverb_sample
    output logic [cfr_pkg::M_TUSER_W-1:0]     m_tuser,   // [0] saturated
    // Configuration channel for tap_count.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfr_pkg::TAP_COUNT_W-1:0]   cfg_data
);

    localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int ACC_W  = 2 * cfr_pkg::SAMPLE_W + ADDR_W + cfr_pkg::FRAC_W;

    localparam logic [31:0]       MAX_TAPS_W = 32'(MAX_TAPS);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(MAX_TAPS - 1);
    localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_TAPS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam int VALUE_LSB = cfr_pkg::TAP_INDEX_W;

    // Input fields.
    logic                                 in_func;
    logic                                 in_start;
    logic [cfr_pkg::TAP_INDEX_W-1:0]      in_index;
    logic signed [cfr_pkg::SAMPLE_W-1:0]  in_value;

    assign in_func  = s_tuser[0];
    assign in_start = s_tuser[1];
    assign in_index = s_tdata[cfr_pkg::TAP_INDEX_W-1:0];
    assign in_value = s_tdata[VALUE_LSB +: cfr_pkg::SAMPLE_W];

    // Memories.
    logic signed [cfr_pkg::SAMPLE_W-1:0] tap_mem  [0:MAX_TAPS-1];
    logic signed [cfr_pkg::SAMPLE_W-1:0] hist_mem [0:MAX_TAPS-1];
    logic signed [cfr_pkg::SAMPLE_W-1:0] tap_q_reg;
    logic signed [cfr_pkg::SAMPLE_W-1:0] hist_q_reg;

    // Control state.
    logic [1:0]                        state_reg, state_next;
    logic [cfr_pkg::TAP_COUNT_W-1:0]   tap_count_reg;
    logic [ADDR_W-1:0]                 wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]                  chunk_cnt_reg, chunk_cnt_next;
    logic [CNT_W-1:0]                  k_reg, k_next;
    logic [CNT_W-1:0]                  n_reg, n_next;
    logic [ADDR_W-1:0]                 pos_reg, pos_next;
    logic                              rd_valid_reg;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [cfr_pkg::OUT_W-1:0]         m_data_reg;
    logic                              m_sat_reg;

    // Handshake and sample bookkeeping.
    logic                              in_xfer;
    logic                              tap_wr;
    logic                              smp_xfer;
    logic                              tap_in_range;
    logic [ADDR_W-1:0]                 newest;
    logic [CNT_W-1:0]                  cnt_base;
    logic [CNT_W-1:0]                  cnt_inc;
    logic [CNT_W-1:0]                  taps_used;
    logic [CNT_W-1:0]                  n_calc;
    logic                              issue;
    logic                              last_issue;
    logic                              load_out;

    // Multiply-accumulate interface.
    cfr_pkg::cfr_mac_ctl_t             mac_ctl;
    logic                              mac_busy;
    logic [cfr_pkg::OUT_W-1:0]         mac_result;
    logic                              mac_sat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid & s_tready;
    assign tap_in_range = ({{(32 - cfr_pkg::TAP_INDEX_W){1'b0}}, in_index} < MAX_TAPS_W);
    assign tap_wr    = in_xfer & ~in_func & tap_in_range;
    assign smp_xfer  = in_xfer & in_func;

    // A chunk start rewinds the ring and the sample count before this sample is stored.
    assign newest   = in_start ? '0 : wr_ptr_reg;
    assign cnt_base = in_start ? '0 : chunk_cnt_reg;
    assign cnt_inc  = (cnt_base == MAX_CNT) ? cnt_base : cnt_base + 1'b1;

    // Taps in use, clamped to the memory depth, then to the samples available.
    assign taps_used = ({{(32 - cfr_pkg::TAP_COUNT_W){1'b0}}, tap_count_reg} > MAX_TAPS_W)
                       ? MAX_CNT : CNT_W'(tap_count_reg);
    assign n_calc    = (taps_used > cnt_inc) ? cnt_inc : taps_used;

    assign issue      = (state_reg == ST_RUN);
    assign last_issue = issue && (k_reg == n_reg - 1'b1);
    assign load_out   = (state_reg == ST_DRAIN) && !rd_valid_reg && !mac_busy
                        && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        chunk_cnt_next = chunk_cnt_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        pos_next       = pos_reg;
        m_tvalid_next  = m_tvalid_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (smp_xfer) begin
                    wr_ptr_next    = (newest == LAST_ADDR) ? '0 : newest + 1'b1;
                    chunk_cnt_next = cnt_inc;
                    n_next         = n_calc;
                    k_next         = '0;
                    pos_next       = newest;
                    // With no taps in use the cleared sum is the result.
                    state_next     = (n_calc == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN: begin
                k_next   = k_reg + 1'b1;
                pos_next = (pos_reg == '0) ? LAST_ADDR : pos_reg - 1'b1;
                if (last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (load_out) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= cfr_pkg::TAP_COUNT_W'(1);
            wr_ptr_reg    <= '0;
            chunk_cnt_reg <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            pos_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            chunk_cnt_reg <= chunk_cnt_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            pos_reg       <= pos_next;
            rd_valid_reg  <= issue;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                tap_count_reg <= cfg_data;
            end
        end
    end

    // Tap memory: written by tap transfers, read once per cycle while the sum runs.
    always_ff @(posedge aclk) begin
        if (tap_wr) begin
            tap_mem[ADDR_W'(in_index)] <= in_value;
        end
        if (issue) begin
            tap_q_reg <= tap_mem[k_reg[ADDR_W-1:0]];
        end
    end

    // History memory: the new sample is written at its transfer, before the
    // first read is issued, so the newest entry never needs forwarding.
    always_ff @(posedge aclk) begin
        if (smp_xfer) begin
            hist_mem[newest] <= in_value;
        end
        if (issue) begin
            hist_q_reg <= hist_mem[pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= mac_result;
            m_sat_reg  <= mac_sat;
        end
    end

    assign mac_ctl.clear    = smp_xfer;
    assign mac_ctl.rd_valid = rd_valid_reg;

    cfr_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .tap_q   (tap_q_reg),
        .hist_q  (hist_q_reg),
        .busy    (mac_busy),
        .result  (mac_result),
        .sat     (mac_sat)
    );

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_sat_reg;

endmodule
